### design/bmpd_pkg.sv
// Shared types and constants of the BMP stream pixel decoder.
package bmpd_pkg;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  // Error codes
  typedef enum logic [2:0] {
    ERR_NOT_BMP    = 3'd0,
    ERR_BAD_HEADER = 3'd1,
    ERR_FORMAT     = 3'd2,
    ERR_SIZE       = 3'd3,
    ERR_TRUNCATED  = 3'd4,
    ERR_OFFSET     = 3'd5
  } err_t;

  // Decoder phases, one-hot
  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_SKIP   = 4'b0010,
    PH_PIXELS = 4'b0100,
    PH_DRAIN  = 4'b1000
  } phase_t;

  // Signature bytes
  localparam logic [7:0] SIG_B = 8'h42;
  localparam logic [7:0] SIG_M = 8'h4D;

  // Byte positions of the last byte of each header field
  localparam logic [31:0] POS_SIG_B     = 32'd0;
  localparam logic [31:0] POS_SIG_M     = 32'd1;
  localparam logic [31:0] POS_OFFSET    = 32'd13;
  localparam logic [31:0] POS_HDR_LEN   = 32'd17;
  localparam logic [31:0] POS_WIDTH     = 32'd21;
  localparam logic [31:0] POS_HEIGHT    = 32'd25;
  localparam logic [31:0] POS_BIT_COUNT = 32'd29;
  localparam logic [31:0] POS_COMPRESS  = 32'd33;
  localparam logic [31:0] POS_HDR_END   = 32'd53;

  // Position of the last file header byte: end of file before it gives "not BMP"
  localparam logic [31:0] FILE_HDR_LEN     = 32'd13;
  localparam logic [31:0] MIN_INFO_HDR_LEN = 32'd40;
  localparam logic [31:0] MIN_PIXEL_OFFSET = 32'd54;
  localparam logic [15:0] BIT_COUNT_24     = 16'd24;
  localparam logic [15:0] BIT_COUNT_32     = 16'd32;
  localparam logic [7:0]  ALPHA_OPAQUE     = 8'd255;

endpackage

### design/bmp_stream_pixel_decoder.sv
// Top level of the BMP stream pixel decoder: header parsing, pixel unpacking, result queue.
//
// Takes a BMP file one byte per clock and produces RGBA pixels with their column and
// top-down row, a header item with the accepted size, and error items. Every byte is
// handled in the cycle it is accepted, so a sustained rate of one byte per cycle is kept
// as long as results are taken. A byte yields at most two items (header plus truncation
// error, or pixel plus truncation error); items go through a four-entry queue and
// in_ready drops only while that queue holds three or more items. Pixels already sent
// are void once an error item follows. After end_of_file the decoder is ready for a new
// file on the next byte.
module bmp_stream_pixel_decoder #(
  parameter int MAX_DIM = 512
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     data_byte,
  input  logic                           end_of_file,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     kind,
  output logic [7:0]                     red,
  output logic [7:0]                     green,
  output logic [7:0]                     blue,
  output logic [7:0]                     alpha,
  output logic [$clog2(MAX_DIM)-1:0]     column,
  output logic [$clog2(MAX_DIM)-1:0]     row,
  output logic [$clog2(MAX_DIM+1)-1:0]   pic_width,
  output logic [$clog2(MAX_DIM+1)-1:0]   pic_height,
  output logic [2:0]                     error_code,
  output logic                           last
);

  import bmpd_pkg::*;

  localparam int DIM_W  = $clog2(MAX_DIM);
  localparam int SIZE_W = $clog2(MAX_DIM + 1);

  typedef struct packed {
    kind_t             kind;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [7:0]        alpha;
    logic [DIM_W-1:0]  column;
    logic [DIM_W-1:0]  row;
    logic [SIZE_W-1:0] pic_width;
    logic [SIZE_W-1:0] pic_height;
    err_t              error_code;
    logic              last;
  } res_t;

  // Decoder state
  phase_t            phase, phase_next;
  logic [31:0]       file_position, file_position_next;
  logic [31:0]       field_assembly, field_assembly_next;
  logic [31:0]       pixel_offset, pixel_offset_next;
  logic              hdr_len_ok, hdr_len_ok_next;
  logic [SIZE_W-1:0] stored_width, stored_width_next;
  logic [SIZE_W-1:0] stored_height, stored_height_next;
  logic              rows_top_down, rows_top_down_next;
  logic              fmt_ok, fmt_ok_next;
  logic              bpp4, bpp4_next;
  logic [23:0]       pixel_bytes, pixel_bytes_next;
  logic [1:0]        comp, comp_next;
  logic [DIM_W-1:0]  column_count, column_count_next;
  logic              in_pad, in_pad_next;
  logic [1:0]        pad_index, pad_index_next;
  logic [DIM_W-1:0]  source_row, source_row_next;

  // Step results
  logic        accept;
  logic [31:0] field_next;
  logic [31:0] height_mag;
  logic [1:0]  pad_len;
  logic [1:0]  comp_last;
  logic        col_last;
  logic        row_last;
  logic        row_end;
  logic        prim_valid;
  logic        err4;
  res_t        prim;
  res_t        err4_res;
  res_t        slot0;
  res_t        slot1;
  res_t        out_res;
  logic [1:0]  push_count;
  logic        has_room;

  function automatic res_t make_error(err_t code);
    res_t r;
    r            = '0;
    r.kind       = KIND_ERROR;
    r.error_code = code;
    r.last       = 1'b1;
    return r;
  endfunction

  assign accept     = in_valid && in_ready;
  assign in_ready   = has_room;
  assign field_next = {data_byte, field_assembly[31:8]};
  assign height_mag = field_next[31] ? (32'd0 - field_next) : field_next;
  assign pad_len    = bpp4 ? 2'd0 : stored_width[1:0];
  assign comp_last  = bpp4 ? 2'd3 : 2'd2;
  assign col_last   = (SIZE_W'(column_count) + SIZE_W'(1)) == stored_width;
  assign row_last   = (SIZE_W'(source_row) + SIZE_W'(1)) == stored_height;
  assign err4_res   = make_error(ERR_TRUNCATED);

  // Per-byte decode
  always_comb begin
    phase_next          = phase;
    file_position_next  = file_position;
    field_assembly_next = field_assembly;
    pixel_offset_next   = pixel_offset;
    hdr_len_ok_next     = hdr_len_ok;
    stored_width_next   = stored_width;
    stored_height_next  = stored_height;
    rows_top_down_next  = rows_top_down;
    fmt_ok_next         = fmt_ok;
    bpp4_next           = bpp4;
    pixel_bytes_next    = pixel_bytes;
    comp_next           = comp;
    column_count_next   = column_count;
    in_pad_next         = in_pad;
    pad_index_next      = pad_index;
    source_row_next     = source_row;
    row_end             = 1'b0;
    prim_valid          = 1'b0;
    prim                = '0;
    err4                = 1'b0;

    if (accept) begin
      case (phase)
        PH_HEADER: begin
          field_assembly_next = field_next;
          file_position_next  = file_position + 32'd1;
          if ((file_position == POS_SIG_B && data_byte != SIG_B) ||
              (file_position == POS_SIG_M && data_byte != SIG_M)) begin
            prim_valid = 1'b1;
            prim       = make_error(ERR_NOT_BMP);
            phase_next = PH_DRAIN;
          end else if (file_position == POS_OFFSET) begin
            pixel_offset_next = field_next;
          end else if (file_position == POS_HDR_LEN) begin
            hdr_len_ok_next = (field_next >= MIN_INFO_HDR_LEN);
          end else if (file_position == POS_WIDTH) begin
            stored_width_next = (field_next != 32'd0 && field_next <= 32'(MAX_DIM)) ?
                                field_next[SIZE_W-1:0] : '0;
          end else if (file_position == POS_HEIGHT) begin
            rows_top_down_next = field_next[31];
            stored_height_next = (height_mag != 32'd0 && height_mag <= 32'(MAX_DIM)) ?
                                 height_mag[SIZE_W-1:0] : '0;
          end else if (file_position == POS_BIT_COUNT) begin
            fmt_ok_next = (field_next[31:16] == BIT_COUNT_24) ||
                          (field_next[31:16] == BIT_COUNT_32);
            bpp4_next   = (field_next[31:16] == BIT_COUNT_32);
          end else if (file_position == POS_COMPRESS) begin
            if (field_next != 32'd0) begin
              fmt_ok_next = 1'b0;
            end
          end else if (file_position == POS_HDR_END) begin
            // checks in fixed priority order
            prim_valid = 1'b1;
            if (!hdr_len_ok) begin
              prim       = make_error(ERR_BAD_HEADER);
              phase_next = PH_DRAIN;
            end else if (!fmt_ok) begin
              prim       = make_error(ERR_FORMAT);
              phase_next = PH_DRAIN;
            end else if (stored_width == '0 || stored_height == '0) begin
              prim       = make_error(ERR_SIZE);
              phase_next = PH_DRAIN;
            end else if (pixel_offset < MIN_PIXEL_OFFSET) begin
              prim       = make_error(ERR_OFFSET);
              phase_next = PH_DRAIN;
            end else begin
              prim.kind         = KIND_HEADER;
              prim.pic_width    = stored_width;
              prim.pic_height   = stored_height;
              phase_next        = (pixel_offset == MIN_PIXEL_OFFSET) ? PH_PIXELS : PH_SKIP;
              comp_next         = 2'd0;
              column_count_next = '0;
              in_pad_next       = 1'b0;
              pad_index_next    = 2'd0;
              source_row_next   = '0;
              pixel_bytes_next  = '0;
            end
          end
          // header cut short by end of file
          if (end_of_file && phase_next == PH_HEADER) begin
            prim_valid = 1'b1;
            prim       = make_error((file_position < FILE_HDR_LEN) ?
                                    ERR_NOT_BMP : ERR_BAD_HEADER);
          end
        end

        PH_SKIP: begin
          file_position_next = file_position + 32'd1;
          if (file_position + 32'd1 == pixel_offset) begin
            phase_next = PH_PIXELS;
          end
        end

        PH_PIXELS: begin
          if (!in_pad) begin
            if (comp != 2'd3) begin
              pixel_bytes_next = {pixel_bytes[15:0], data_byte};
            end
            if (comp == comp_last) begin
              // pixel complete: stored order is B, G, R
              prim_valid  = 1'b1;
              prim.kind   = KIND_PIXEL;
              prim.red    = pixel_bytes_next[7:0];
              prim.green  = pixel_bytes_next[15:8];
              prim.blue   = pixel_bytes_next[23:16];
              prim.alpha  = bpp4 ? data_byte : ALPHA_OPAQUE;
              prim.column = column_count;
              prim.row    = rows_top_down ? source_row :
                            DIM_W'(stored_height - SIZE_W'(1) - SIZE_W'(source_row));
              prim.last   = row_last && col_last;
              comp_next   = 2'd0;
              if (col_last) begin
                if (pad_len == 2'd0) begin
                  row_end = 1'b1;
                end else begin
                  in_pad_next    = 1'b1;
                  pad_index_next = 2'd0;
                end
              end else begin
                column_count_next = column_count + DIM_W'(1);
              end
            end else begin
              comp_next = comp + 2'd1;
            end
          end else begin
            // row padding to a multiple of four bytes
            if (pad_index + 2'd1 == pad_len) begin
              row_end = 1'b1;
            end else begin
              pad_index_next = pad_index + 2'd1;
            end
          end
          if (row_end) begin
            in_pad_next       = 1'b0;
            column_count_next = '0;
            source_row_next   = source_row + DIM_W'(1);
            if (row_last) begin
              phase_next = PH_DRAIN;
            end
          end
        end

        PH_DRAIN: begin
        end

        default: begin
          phase_next = PH_DRAIN;
        end
      endcase

      // end of file before the pixel data is complete
      if (end_of_file && (phase_next == PH_SKIP || phase_next == PH_PIXELS)) begin
        err4 = 1'b1;
      end
      if (end_of_file) begin
        phase_next         = PH_HEADER;
        file_position_next = '0;
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      file_position <= '0;
      comp          <= 2'd0;
      column_count  <= '0;
      in_pad        <= 1'b0;
      pad_index     <= 2'd0;
      source_row    <= '0;
    end else begin
      phase         <= phase_next;
      file_position <= file_position_next;
      comp          <= comp_next;
      column_count  <= column_count_next;
      in_pad        <= in_pad_next;
      pad_index     <= pad_index_next;
      source_row    <= source_row_next;
    end
  end

  // Header fields and pixel assembly
  always_ff @(posedge clk) begin
    field_assembly <= field_assembly_next;
    pixel_offset   <= pixel_offset_next;
    hdr_len_ok     <= hdr_len_ok_next;
    stored_width   <= stored_width_next;
    stored_height  <= stored_height_next;
    rows_top_down  <= rows_top_down_next;
    fmt_ok         <= fmt_ok_next;
    bpp4           <= bpp4_next;
    pixel_bytes    <= pixel_bytes_next;
  end

  // Items to the queue: truncation error always goes last
  assign slot0      = prim_valid ? prim : err4_res;
  assign slot1      = err4_res;
  assign push_count = 2'(prim_valid) + 2'(err4);

  bmpd_res_queue #(
    .WIDTH($bits(res_t))
  ) u_res_queue (
    .clk       (clk),
    .rst       (rst),
    .push_count(push_count),
    .push_data0(slot0),
    .push_data1(slot1),
    .has_room  (has_room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_res)
  );

  assign kind         = out_res.kind;
  assign red          = out_res.red;
  assign green        = out_res.green;
  assign blue         = out_res.blue;
  assign alpha        = out_res.alpha;
  assign column       = out_res.column;
  assign row          = out_res.row;
  assign pic_width    = out_res.pic_width;
  assign pic_height   = out_res.pic_height;
  assign error_code   = out_res.error_code;
  assign last         = out_res.last;

  // Checks
  a_eof_restart: assert property (@(posedge clk) disable iff (rst)
    accept && end_of_file |=> phase == PH_HEADER && file_position == '0)
    else $error("decoder did not restart after end of file");

  a_pixels_valid_hdr: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PIXELS |-> fmt_ok && stored_width != '0 && stored_height != '0)
    else $error("pixel phase entered with a rejected header");

  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PIXELS |-> SIZE_W'(source_row) < stored_height)
    else $error("source row ran past image height");

endmodule

### design/bmpd_res_queue.sv
// Four-entry result queue with a two-item write and a one-item read per cycle.
module bmpd_res_queue #(
  parameter int WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [1:0]       push_count,
  input  logic [WIDTH-1:0] push_data0,
  input  logic [WIDTH-1:0] push_data1,
  output logic             has_room,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  localparam int QDEPTH = 4;
  localparam int PTR_W  = $clog2(QDEPTH);
  localparam int LVL_W  = $clog2(QDEPTH + 1);

  logic [WIDTH-1:0] mem [QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [LVL_W-1:0] level;
  logic             pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (level != '0);
  assign out_data  = mem[rd_ptr];
  // room for the worst case of two items from one byte
  assign has_room  = (level <= LVL_W'(QDEPTH - 2));

  // Entry storage
  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      mem[wr_ptr] <= push_data0;
    end
    if (push_count == 2'd2) begin
      mem[wr_ptr + PTR_W'(1)] <= push_data1;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_count);
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      level <= level + LVL_W'(push_count) - LVL_W'(pop);
    end
  end

endmodule
